// ===== design/snowstep_pkg.sv =====
// ============================================================================
// Snowstep package
// Shared types, widths, constants and helpers for the daily snowpack step.
// ============================================================================
package snowstep_pkg;

    // Field widths.
    localparam int WATER_W = 24;
    localparam int TEMP_W  = 12;
    localparam int SLOPE_W = 12;
    localparam int CFG_IDX_W = 2;

    typedef logic [WATER_W-1:0]        water_t;
    typedef logic signed [TEMP_W-1:0]  temp_t;
    typedef logic [SLOPE_W-1:0]        slope_t;
    typedef logic [CFG_IDX_W-1:0]      cfg_idx_t;

    // Configuration register indexes.
    localparam cfg_idx_t CFG_MELT_TEMP  = 2'd0;
    localparam cfg_idx_t CFG_MELT_SLOPE = 2'd1;

    // Reset values of the configuration registers.
    localparam temp_t  MELT_TEMP_RST  = 12'sd0;
    localparam slope_t MELT_SLOPE_RST = 12'd179;

    // Snow falls when the minimum temperature is at or below -1 C (Q8.4).
    localparam temp_t  COLD_LIMIT = -12'sd16;

    // Sublimation fraction of the evaporation demand, in 1/256 units.
    localparam logic [7:0] SUB_NUM = 8'd223;

    // Saturating add of two water amounts.
    function automatic water_t add_sat(input water_t a, input water_t b);
        logic [WATER_W:0] sum;
        sum = {1'b0, a} + {1'b0, b};
        return sum[WATER_W] ? {WATER_W{1'b1}} : sum[WATER_W-1:0];
    endfunction

endpackage

// ===== design/snowstep_smul.sv =====
// ============================================================================
// Snowstep serial multiplier
// Unsigned shift-add multiplier that consumes one multiplier bit per cycle.
// ============================================================================
module snowstep_smul
    import snowstep_pkg::*;
#(
    parameter int AW = 24,
    parameter int BW = 24
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [AW-1:0]     a,
    input  logic [BW-1:0]     b,
    output logic              done,
    output logic [AW+BW-1:0]  product
);

    localparam int CW = $clog2(BW + 1);
    localparam logic [CW-1:0] CNT_INIT = CW'(BW);
    localparam logic [CW-1:0] CNT_ONE  = CW'(1);

    logic [AW+BW-1:0] acc_reg,  acc_next;
    logic [AW-1:0]    a_reg,    a_next;
    logic [CW-1:0]    cnt_reg,  cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [AW:0]      hi_sum;

    // One step: add the multiplicand on a set low bit, then shift right.
    always_comb
    begin
        acc_next  = acc_reg;
        a_next    = a_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        hi_sum    = {1'b0, acc_reg[AW+BW-1:BW]}
                  + (acc_reg[0] ? {1'b0, a_reg} : {(AW+1){1'b0}});
        if (start)
        begin
            acc_next  = {{AW{1'b0}}, b};
            a_next    = a;
            cnt_next  = CNT_INIT;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            acc_next = {hi_sum, acc_reg[BW-1:1]};
            cnt_next = cnt_reg - CNT_ONE;
            if (cnt_reg == CNT_ONE)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        a_reg   <= a_next;
    end

    assign done    = done_reg;
    assign product = acc_reg;

endmodule

// ===== design/snowstep_sdiv.sv =====
// ============================================================================
// Snowstep serial divider
// Restoring divider that develops one quotient bit per cycle. The caller
// guarantees that the quotient fits in QW bits.
// ============================================================================
module snowstep_sdiv
    import snowstep_pkg::*;
#(
    parameter int QW = 24,
    parameter int DW = 25
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic [QW+DW-2:0]     dividend,
    input  logic [DW-1:0]        divisor,
    output logic                 done,
    output logic [QW-1:0]        quotient
);

    localparam int CW = $clog2(QW + 1);
    localparam logic [CW-1:0] CNT_INIT = CW'(QW);
    localparam logic [CW-1:0] CNT_ONE  = CW'(1);

    logic [DW-1:0] rem_reg,  rem_next;
    logic [QW-1:0] sh_reg,   sh_next;
    logic [DW-1:0] dvs_reg,  dvs_next;
    logic [CW-1:0] cnt_reg,  cnt_next;
    logic          busy_reg, busy_next;
    logic          done_reg, done_next;
    logic [DW:0]   trial;
    logic          fits;

    // One step: trial subtract of the divisor from the shifted remainder.
    always_comb
    begin
        rem_next  = rem_reg;
        sh_next   = sh_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial     = {rem_reg, sh_reg[QW-1]} - {1'b0, dvs_reg};
        fits      = !trial[DW];
        if (start)
        begin
            rem_next  = {1'b0, dividend[QW+DW-2:QW]};
            sh_next   = dividend[QW-1:0];
            dvs_next  = divisor;
            cnt_next  = CNT_INIT;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            rem_next = fits ? trial[DW-1:0] : {rem_reg[DW-2:0], sh_reg[QW-1]};
            sh_next  = {sh_reg[QW-2:0], fits};
            cnt_next = cnt_reg - CNT_ONE;
            if (cnt_reg == CNT_ONE)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        sh_reg  <= sh_next;
        dvs_reg <= dvs_next;
    end

    assign done     = done_reg;
    assign quotient = sh_reg;

endmodule

// ===== design/snowpack_daily_step_core.sv =====
// ============================================================================
// Snowpack daily step core
// One day of a degree-day snowpack: snowfall, melt, rain on snow, drainage
// and proportional sublimation, with the pack held between words.
// ============================================================================
// After an input word is taken the sequencer steps through prep, the 12-step melt
// multiply, melt, liquid, drain and sublimation; when snow remains after drainage,
// the 24-step share multiplies and the 24-step share divides follow before the
// result goes to the output register. A new word is taken only while idle; a
// result still held there when the next word ends stalls the sequencer.
// Reset clears the pack to zero and loads the melt registers with defaults.
module snowpack_daily_step_core
    import snowstep_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    // Configuration write channel.
    input  logic      cfg_valid,
    output logic      cfg_ready,
    input  cfg_idx_t  cfg_index,
    input  logic [11:0] cfg_data,
    // Input channel.
    input  logic      in_valid,
    output logic      in_stall,
    input  water_t    precip,
    input  temp_t     min_temp,
    input  temp_t     max_temp,
    input  water_t    pet_in,
    // Output channel.
    output logic      out_valid,
    input  logic      out_stall,
    output water_t    soil_water,
    output water_t    drain_water,
    output water_t    snow_added,
    output water_t    sublimated,
    output water_t    pet_left,
    output water_t    snow_out,
    output water_t    liquid_out
);

    // Sequencer states.
    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_PREP  = 4'd1;
    localparam logic [3:0] S_MMUL  = 4'd2;
    localparam logic [3:0] S_MELT  = 4'd3;
    localparam logic [3:0] S_LIQ   = 4'd4;
    localparam logic [3:0] S_DRAIN = 4'd5;
    localparam logic [3:0] S_SUBP  = 4'd6;
    localparam logic [3:0] S_SMUL  = 4'd7;
    localparam logic [3:0] S_SDIV  = 4'd8;
    localparam logic [3:0] S_APPLY = 4'd9;
    localparam logic [3:0] S_FIN   = 4'd10;

    logic [3:0] state_reg, state_next;

    // Configuration and pack state.
    temp_t  melt_temp_reg,  melt_temp_next;
    slope_t melt_slope_reg, melt_slope_next;
    water_t snow_reg,       snow_next;
    water_t liq_reg,        liq_next;

    // Working registers of the current word.
    water_t precip_reg,  precip_next;
    temp_t  min_reg,     min_next;
    temp_t  max_reg,     max_next;
    water_t pet_reg,     pet_next;
    water_t soil_reg,    soil_next;
    water_t drain_reg,   drain_next;
    water_t added_reg,   added_next;
    water_t rain_reg,    rain_next;
    water_t sraw_reg,    sraw_next;
    water_t mamt_reg,    mamt_next;
    logic   apply_reg,   apply_next;
    water_t sub_reg,     sub_next;
    water_t pleft_reg,   pleft_next;
    logic [WATER_W:0] total_reg, total_next;

    // Output register.
    logic   ovalid_reg, ovalid_next;
    water_t o_soil_reg,  o_soil_next;
    water_t o_drain_reg, o_drain_next;
    water_t o_added_reg, o_added_next;
    water_t o_sub_reg,   o_sub_next;
    water_t o_pleft_reg, o_pleft_next;
    water_t o_snow_reg,  o_snow_next;
    water_t o_liq_reg,   o_liq_next;

    // Serial unit connections.
    logic        mmul_start, mmul_done;
    logic [11:0] mmul_b;
    logic [23:0] mmul_prod;
    logic        smul_start, smul_done_s, smul_done_l;
    water_t      smul_b;
    logic [2*WATER_W-1:0] prod_s, prod_l;
    logic        sdiv_start, sdiv_done_s, sdiv_done_l;
    water_t      q_s, q_l;

    // Combinational helpers.
    logic signed [TEMP_W:0] diff;
    logic [31:0]            pet_x;
    water_t                 melt_val;
    water_t                 liq_rain;
    water_t                 keep;
    water_t                 drained;
    logic [WATER_W:0]       total_w;
    water_t                 s_cap;
    logic                   in_take, out_take;

    assign in_take  = in_valid && !in_stall;
    assign out_take = ovalid_reg && !out_stall;

    // Degree difference and the melt multiplier operand (zero when d <= 0).
    assign diff   = {max_reg[TEMP_W-1], max_reg} - {melt_temp_reg[TEMP_W-1], melt_temp_reg};
    assign mmul_b = (!diff[TEMP_W] && (diff != '0)) ? diff[TEMP_W-1:0] : 12'd0;

    // Sublimation demand before the cap.
    assign pet_x  = {8'd0, pet_reg} * {24'd0, SUB_NUM};

    assign melt_val = {4'd0, mmul_prod[23:4]};
    assign liq_rain = (snow_reg != '0) ? add_sat(liq_reg, rain_reg) : liq_reg;
    assign keep     = {1'b0, snow_reg[WATER_W-1:1]};
    assign drained  = liq_reg - keep;
    assign total_w  = {1'b0, snow_reg} + {1'b0, liq_reg};
    assign s_cap    = ({1'b0, sraw_reg} > total_w) ? total_w[WATER_W-1:0] : sraw_reg;
    assign smul_b   = s_cap;

    assign mmul_start = (state_reg == S_PREP);
    assign smul_start = (state_reg == S_SUBP) && (snow_reg != '0);
    assign sdiv_start = (state_reg == S_SMUL) && smul_done_s;

    // Sequencer and datapath next-state logic.
    always_comb
    begin
        state_next      = state_reg;
        melt_temp_next  = melt_temp_reg;
        melt_slope_next = melt_slope_reg;
        snow_next       = snow_reg;
        liq_next        = liq_reg;
        precip_next     = precip_reg;
        min_next        = min_reg;
        max_next        = max_reg;
        pet_next        = pet_reg;
        soil_next       = soil_reg;
        drain_next      = drain_reg;
        added_next      = added_reg;
        rain_next       = rain_reg;
        sraw_next       = sraw_reg;
        mamt_next       = mamt_reg;
        apply_next      = apply_reg;
        sub_next        = sub_reg;
        pleft_next      = pleft_reg;
        total_next      = total_reg;
        ovalid_next     = out_take ? 1'b0 : ovalid_reg;
        o_soil_next     = o_soil_reg;
        o_drain_next    = o_drain_reg;
        o_added_next    = o_added_reg;
        o_sub_next      = o_sub_reg;
        o_pleft_next    = o_pleft_reg;
        o_snow_next     = o_snow_reg;
        o_liq_next      = o_liq_reg;

        // Configuration writes; unknown indexes are ignored.
        if (cfg_valid && cfg_ready)
        begin
            if (cfg_index == CFG_MELT_TEMP)
            begin
                melt_temp_next = cfg_data;
            end
            else if (cfg_index == CFG_MELT_SLOPE)
            begin
                melt_slope_next = cfg_data;
            end
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_take)
                begin
                    precip_next = precip;
                    min_next    = min_temp;
                    max_next    = max_temp;
                    pet_next    = pet_in;
                    state_next  = S_PREP;
                end
            end
            // Snowfall or rain, and the uncapped sublimation demand.
            S_PREP:
            begin
                drain_next = '0;
                sraw_next  = pet_x[31:8];
                if (min_reg <= COLD_LIMIT)
                begin
                    snow_next  = add_sat(snow_reg, precip_reg);
                    added_next = precip_reg;
                    soil_next  = '0;
                    rain_next  = '0;
                end
                else
                begin
                    added_next = '0;
                    soil_next  = precip_reg;
                    rain_next  = precip_reg;
                end
                state_next = S_MMUL;
            end
            S_MMUL:
            begin
                if (mmul_done)
                begin
                    state_next = S_MELT;
                end
            end
            // Melt, clamped to the pack.
            S_MELT:
            begin
                apply_next = (snow_reg != '0) && (max_reg > 12'sd0);
                mamt_next  = '0;
                if ((snow_reg != '0) && (max_reg > 12'sd0))
                begin
                    if (melt_val < snow_reg)
                    begin
                        snow_next = snow_reg - melt_val;
                        mamt_next = melt_val;
                    end
                    else
                    begin
                        snow_next = '0;
                        mamt_next = snow_reg;
                    end
                end
                state_next = S_LIQ;
            end
            // Rain on a surviving pack, then the melt water.
            S_LIQ:
            begin
                if (apply_reg)
                begin
                    liq_next = add_sat(liq_rain, mamt_reg);
                end
                state_next = S_DRAIN;
            end
            // Liquid above half the snow drains to the soil.
            S_DRAIN:
            begin
                if (apply_reg && ({liq_reg, 1'b0} > {1'b0, snow_reg}))
                begin
                    liq_next   = keep;
                    drain_next = drained;
                    soil_next  = add_sat(soil_reg, drained);
                end
                state_next = S_SUBP;
            end
            // Capped sublimation; shares are found by the serial units.
            S_SUBP:
            begin
                if (snow_reg != '0)
                begin
                    total_next = total_w;
                    sub_next   = s_cap;
                    pleft_next = pet_reg - s_cap;
                    state_next = S_SMUL;
                end
                else
                begin
                    sub_next   = '0;
                    pleft_next = pet_reg;
                    state_next = S_FIN;
                end
            end
            S_SMUL:
            begin
                if (smul_done_s)
                begin
                    state_next = S_SDIV;
                end
            end
            // Both lanes run in lockstep, so their done flags rise together.
            S_SDIV:
            begin
                if (sdiv_done_s && sdiv_done_l)
                begin
                    state_next = S_APPLY;
                end
            end
            S_APPLY:
            begin
                snow_next  = snow_reg - q_s;
                liq_next   = liq_reg - q_l;
                state_next = S_FIN;
            end
            // Hand the word to the output register once it is free.
            S_FIN:
            begin
                if (!ovalid_reg || !out_stall)
                begin
                    ovalid_next  = 1'b1;
                    o_soil_next  = soil_reg;
                    o_drain_next = drain_reg;
                    o_added_next = added_reg;
                    o_sub_next   = sub_reg;
                    o_pleft_next = pleft_reg;
                    o_snow_next  = snow_reg;
                    o_liq_next   = liq_reg;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control, configuration and pack state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            melt_temp_reg  <= MELT_TEMP_RST;
            melt_slope_reg <= MELT_SLOPE_RST;
            snow_reg       <= '0;
            liq_reg        <= '0;
            apply_reg      <= 1'b0;
            ovalid_reg     <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            melt_temp_reg  <= melt_temp_next;
            melt_slope_reg <= melt_slope_next;
            snow_reg       <= snow_next;
            liq_reg        <= liq_next;
            apply_reg      <= apply_next;
            ovalid_reg     <= ovalid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        precip_reg  <= precip_next;
        min_reg     <= min_next;
        max_reg     <= max_next;
        pet_reg     <= pet_next;
        soil_reg    <= soil_next;
        drain_reg   <= drain_next;
        added_reg   <= added_next;
        rain_reg    <= rain_next;
        sraw_reg    <= sraw_next;
        mamt_reg    <= mamt_next;
        sub_reg     <= sub_next;
        pleft_reg   <= pleft_next;
        total_reg   <= total_next;
        o_soil_reg  <= o_soil_next;
        o_drain_reg <= o_drain_next;
        o_added_reg <= o_added_next;
        o_sub_reg   <= o_sub_next;
        o_pleft_reg <= o_pleft_next;
        o_snow_reg  <= o_snow_next;
        o_liq_reg   <= o_liq_next;
    end

    // Melt multiplier: slope times degrees above base.
    snowstep_smul #(
        .AW (SLOPE_W),
        .BW (12)
    ) u_melt_mul (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (mmul_start),
        .a       (melt_slope_reg),
        .b       (mmul_b),
        .done    (mmul_done),
        .product (mmul_prod)
    );

    // Sublimation share products for snow and liquid.
    snowstep_smul #(
        .AW (WATER_W),
        .BW (WATER_W)
    ) u_snow_mul (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (smul_start),
        .a       (snow_reg),
        .b       (smul_b),
        .done    (smul_done_s),
        .product (prod_s)
    );

    snowstep_smul #(
        .AW (WATER_W),
        .BW (WATER_W)
    ) u_liq_mul (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (smul_start),
        .a       (liq_reg),
        .b       (smul_b),
        .done    (smul_done_l),
        .product (prod_l)
    );

    // Division of each share product by the pack total.
    snowstep_sdiv #(
        .QW (WATER_W),
        .DW (WATER_W + 1)
    ) u_snow_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (sdiv_start),
        .dividend (prod_s),
        .divisor  (total_reg),
        .done     (sdiv_done_s),
        .quotient (q_s)
    );

    snowstep_sdiv #(
        .QW (WATER_W),
        .DW (WATER_W + 1)
    ) u_liq_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (sdiv_start && smul_done_l),
        .dividend (prod_l),
        .divisor  (total_reg),
        .done     (sdiv_done_l),
        .quotient (q_l)
    );

    // A new word is taken only while the sequencer is idle.
    assign in_stall    = (state_reg != S_IDLE);
    assign cfg_ready   = 1'b1;
    assign out_valid   = ovalid_reg;
    assign soil_water  = o_soil_reg;
    assign drain_water = o_drain_reg;
    assign snow_added  = o_added_reg;
    assign sublimated  = o_sub_reg;
    assign pet_left    = o_pleft_reg;
    assign snow_out    = o_snow_reg;
    assign liquid_out  = o_liq_reg;

endmodule
